FILE: rtl/core/tlfq_pkg.sv
package tlfq_pkg;

	localparam int MAX_JOBS    = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int BURST_BITS  = 16;
	localparam int ID_W        = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W      = $clog2(MAX_JOBS);

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [0:0] REG_QUANTUM_TOP = 1'b0;
	localparam logic [0:0] REG_QUANTUM_MID = 1'b1;

	localparam logic [1:0] LVL_TOP = 2'd0;
	localparam logic [1:0] LVL_MID = 2'd1;
	localparam logic [1:0] LVL_BOT = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [3:0] job_id;
		logic [15:0] burst_len;
	} req_t;

	typedef struct packed {
		logic       accepted;
		logic       run_valid;
		logic [3:0] run_id;
		logic [1:0] run_level;
		logic       finished;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture the request and read queue heads
		logic execute; // perform the step and register the result
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic busy_unused;
	} sts_t;

endpackage

FILE: rtl/core/tlfq_if.sv
interface tlfq_req_if;
	logic            valid;
	logic            ready;
	tlfq_pkg::req_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tlfq_rsp_if;
	logic            valid;
	logic            ready;
	tlfq_pkg::rsp_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tlfq_ctrl.sv
module tlfq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tlfq_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// A request is taken whenever no step is running and the result slot is free
	// or being emptied this cycle.
	assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign cmd.load    = in_valid && in_ready;
	assign cmd.execute = (state_q == S_EXEC);
	assign out_valid   = out_valid_q;

	// Sequencer and result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_EXEC;
				S_EXEC: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/tlfq_dp.sv
module tlfq_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  tlfq_pkg::cmd_t   cmd,
	input  tlfq_pkg::req_t   req,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_idx,
	input  logic [7:0]       cfg_data,
	output tlfq_pkg::rsp_t   rsp
);

	localparam int QP = tlfq_pkg::QP_W;
	localparam int QC = tlfq_pkg::QC_W;
	localparam int BB = tlfq_pkg::BURST_BITS;
	localparam int SW = tlfq_pkg::SLOT_W;
	localparam int IW = tlfq_pkg::ID_W;

	// Queue storage, one memory per level, and burst memory.
	logic [IW-1:0] q0_mem [tlfq_pkg::QUEUE_DEPTH];
	logic [IW-1:0] q1_mem [tlfq_pkg::QUEUE_DEPTH];
	logic [IW-1:0] q2_mem [tlfq_pkg::QUEUE_DEPTH];
	logic [BB-1:0] burst_mem [tlfq_pkg::MAX_JOBS];

	logic [QP-1:0] head_q [3];
	logic [QP-1:0] tail_q [3];
	logic [QC-1:0] cnt_q [3];
	logic          act_valid_q;
	logic [1:0]    act_level_q;
	logic [IW-1:0] act_id_q;
	logic [7:0]    slice_q;
	logic          saved_valid_q;
	logic [7:0]    saved_slice_q;
	logic [7:0]    qtop_q, qmid_q;

	tlfq_pkg::req_t req_q;
	logic [IW-1:0]  h0_q, h1_q, h2_q;
	tlfq_pkg::rsp_t rsp_q;

	assign rsp = rsp_q;

	function automatic logic [QP-1:0] nxt(input logic [QP-1:0] p);
		nxt = (32'(p) + 1 >= tlfq_pkg::QUEUE_DEPTH) ? '0 : p + 1'b1;
	endfunction

	// Load: registered capture of the request and reads of the queue heads.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= req;
			h0_q        <= q0_mem[head_q[0]];
			h1_q        <= q1_mem[head_q[1]];
			h2_q        <= q2_mem[head_q[2]];
		end
	end

	// Choice of the job to run, from registered heads.
	logic          sel_none, sel_new;
	logic [1:0]    n_level;
	logic [IW-1:0] n_id;
	logic [7:0]    n_slice;
	logic          n_save;

	always_comb begin
		sel_none = 1'b0;
		sel_new  = 1'b0;
		n_level  = act_level_q;
		n_id     = act_id_q;
		n_slice  = slice_q;
		n_save   = 1'b0;
		if (!(act_valid_q && act_level_q != tlfq_pkg::LVL_MID)) begin
			if (cnt_q[0] != '0) begin
				sel_new = 1'b1;
				n_save  = act_valid_q;
				n_id    = h0_q;
				n_level = tlfq_pkg::LVL_TOP;
				n_slice = qtop_q;
			end else if (!act_valid_q) begin
				if (cnt_q[1] != '0) begin
					sel_new = 1'b1;
					n_id    = h1_q;
					n_level = tlfq_pkg::LVL_MID;
					n_slice = saved_valid_q ? saved_slice_q : qmid_q;
				end else if (cnt_q[2] != '0) begin
					sel_new = 1'b1;
					n_id    = h2_q;
					n_level = tlfq_pkg::LVL_BOT;
					n_slice = '0;
				end else begin
					sel_none = 1'b1;
				end
			end
		end
	end

	// Burst of the chosen job, read as a small register file.
	logic [BB-1:0] cur_b, new_b;
	logic [7:0]    new_slice;
	logic          fin, demote0, demote1;
	logic          is_arr, tick_run;

	assign is_arr    = (req_q.opcode == tlfq_pkg::OP_ARRIVE);
	assign tick_run  = !is_arr && !sel_none;
	assign cur_b     = burst_mem[n_id[SW-1:0]];
	assign new_b     = (cur_b != '0) ? cur_b - 1'b1 : cur_b;
	assign new_slice = (n_slice != '0) ? n_slice - 1'b1 : n_slice;
	assign fin       = (new_b == '0);
	assign demote0   = !fin && n_level == tlfq_pkg::LVL_TOP && new_slice == '0;
	assign demote1   = !fin && n_level == tlfq_pkg::LVL_MID && new_slice == '0;

	logic push0_ok, pop0, pop1, pop2, push1, push2;
	assign push0_ok = is_arr && (cnt_q[0] < QC'(tlfq_pkg::QUEUE_DEPTH));
	assign pop0  = tick_run && sel_new && n_level == tlfq_pkg::LVL_TOP;
	assign pop2  = tick_run && sel_new && n_level == tlfq_pkg::LVL_BOT;
	assign pop1  = tick_run && n_level == tlfq_pkg::LVL_MID && (fin || demote1);
	assign push1 = tick_run && demote0 && (cnt_q[1] < QC'(tlfq_pkg::QUEUE_DEPTH));
	assign push2 = tick_run && demote1 && (cnt_q[2] < QC'(tlfq_pkg::QUEUE_DEPTH));

	// Memory writes of the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (push0_ok) begin
				q0_mem[tail_q[0]] <= req_q.job_id;
				burst_mem[req_q.job_id[SW-1:0]] <= req_q.burst_len[BB-1:0];
			end
			if (tick_run) burst_mem[n_id[SW-1:0]] <= new_b;
			if (push1) q1_mem[tail_q[1]] <= n_id;
			if (push2) q2_mem[tail_q[2]] <= n_id;
		end
	end

	// Pointers, counts and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			act_valid_q   <= 1'b0;
			act_level_q   <= '0;
			act_id_q      <= '0;
			slice_q       <= '0;
			saved_valid_q <= 1'b0;
			saved_slice_q <= '0;
			qtop_q        <= 8'd2;
			qmid_q        <= 8'd4;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tlfq_pkg::REG_QUANTUM_TOP: qtop_q <= cfg_data;
					tlfq_pkg::REG_QUANTUM_MID: qmid_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.execute) begin
				if (push0_ok) begin
					tail_q[0] <= nxt(tail_q[0]);
					cnt_q[0]  <= cnt_q[0] + 1'b1;
				end
				if (pop0) begin
					head_q[0] <= nxt(head_q[0]);
					cnt_q[0]  <= cnt_q[0] - 1'b1;
				end
				if (pop1 && !push1) begin
					head_q[1] <= nxt(head_q[1]);
					cnt_q[1]  <= cnt_q[1] - 1'b1;
				end
				if (push1) begin
					tail_q[1] <= nxt(tail_q[1]);
					cnt_q[1]  <= cnt_q[1] + 1'b1;
				end
				if (pop2 && !push2) begin
					head_q[2] <= nxt(head_q[2]);
					cnt_q[2]  <= cnt_q[2] - 1'b1;
				end
				if (push2) begin
					tail_q[2] <= nxt(tail_q[2]);
					cnt_q[2]  <= cnt_q[2] + 1'b1;
				end
				if (tick_run) begin
					if (n_save) begin
						saved_valid_q <= 1'b1;
						saved_slice_q <= slice_q;
					end else if (sel_new && n_level == tlfq_pkg::LVL_MID) begin
						saved_valid_q <= 1'b0;
					end
					act_level_q <= n_level;
					act_id_q    <= n_id;
					slice_q     <= new_slice;
					act_valid_q <= !(fin || demote0 || demote1);
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp_q.accepted  <= push0_ok;
			rsp_q.run_valid <= tick_run;
			rsp_q.run_id    <= tick_run ? n_id : '0;
			rsp_q.run_level <= tick_run ? n_level : '0;
			rsp_q.finished  <= tick_run && fin;
		end
	end

endmodule

FILE: rtl/core/three_level_feedback_queue_scheduler.sv
// Timing: a request is taken, the step runs in the next cycle, and the result
// is registered at the end of that step and then offered.
// Throughput: a request is not taken while a step runs or while a result waits
// unaccepted, as the queue memories in the datapath are read and then updated.
// Reset: arst_n clears all queues and the active job, and sets the quanta to 2 and 4.
module three_level_feedback_queue_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	tlfq_req_if.sink   req,
	tlfq_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [7:0] cfg_data
);

	tlfq_pkg::cmd_t cmd;

	tlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	tlfq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req.payload),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rsp      (rsp.payload)
	);

endmodule

FILE: rtl/core/tlfq_checker.sv
module tlfq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tlfq_pkg::rsp_t out_payload
);

	// A result never reports both an arrival and a tick.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_payload.accepted && out_payload.run_valid))
		else $error("accepted and run_valid both set");

	// Finished only comes with a run.
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.finished |-> out_payload.run_valid)
		else $error("finished without a run");

	// No new request is taken in the cycle after one was taken.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back to back acceptance");

	// A result is offered after the step that follows each acceptance.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing");

endmodule

bind three_level_feedback_queue_scheduler tlfq_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.out_payload (rsp.payload)
);

FILE: tb/sv/tb_three_level_feedback_queue_scheduler.sv
module tb_three_level_feedback_queue_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	// Scheduler state as the predictor sees it.
	class sched_board;
		logic [3:0] lq [3][tlfq_pkg::QUEUE_DEPTH];
		int unsigned head [3];
		int unsigned tail [3];
		int unsigned cnt [3];
		logic [15:0] burst [tlfq_pkg::MAX_JOBS];
		bit act_v;
		logic [1:0] act_lvl;
		logic [3:0] act_id;
		int unsigned slice;
		bit saved_v;
		int unsigned saved_slice;
		logic [7:0] q_top;
		logic [7:0] q_mid;
		tlfq_pkg::rsp_t pending [$];
		int errors;

		function void clear();
			for (int l = 0; l < 3; l++) begin
				head[l] = 0; tail[l] = 0; cnt[l] = 0;
			end
			act_v = 0; act_lvl = tlfq_pkg::LVL_TOP; act_id = 0; slice = 0;
			saved_v = 0; saved_slice = 0;
			q_top = 8'd2; q_mid = 8'd4; errors = 0;
		endfunction

		function bit push(int l, logic [3:0] id);
			if (cnt[l] >= tlfq_pkg::QUEUE_DEPTH) return 0;
			lq[l][tail[l]] = id;
			tail[l] = (tail[l] + 1 >= tlfq_pkg::QUEUE_DEPTH) ? 0 : tail[l] + 1;
			cnt[l]++;
			return 1;
		endfunction

		function void pop(int l);
			if (cnt[l] == 0) return;
			head[l] = (head[l] + 1 >= tlfq_pkg::QUEUE_DEPTH) ? 0 : head[l] + 1;
			cnt[l]--;
		endfunction

		// Note an accepted request and queue its expected result.
		function void note_request(tlfq_pkg::req_t r);
			tlfq_pkg::rsp_t o;
			logic [15:0] b;
			bit ran;
			o = '0;
			ran = 1;
			if (r.opcode == tlfq_pkg::OP_ARRIVE) begin
				if (push(0, r.job_id)) begin
					burst[r.job_id] = r.burst_len;
					o.accepted = 1;
				end
				pending.push_back(o);
				return;
			end
			if (!(act_v && act_lvl != tlfq_pkg::LVL_MID)) begin
				if (cnt[0] != 0) begin
					if (act_v) begin
						saved_v = 1; saved_slice = slice;
					end
					act_id = lq[0][head[0]]; pop(0);
					act_lvl = tlfq_pkg::LVL_TOP; act_v = 1; slice = q_top;
				end else if (!act_v) begin
					if (cnt[1] != 0) begin
						act_id = lq[1][head[1]]; act_lvl = tlfq_pkg::LVL_MID; act_v = 1;
						slice = saved_v ? saved_slice : q_mid;
						saved_v = 0;
					end else if (cnt[2] != 0) begin
						act_id = lq[2][head[2]]; pop(2);
						act_lvl = tlfq_pkg::LVL_BOT; act_v = 1; slice = 0;
					end else begin
						ran = 0;
					end
				end
			end
			if (ran) begin
				b = burst[act_id];
				if (b != 0) b--;
				burst[act_id] = b;
				if (slice != 0) slice--;
				o.run_valid = 1; o.run_id = act_id; o.run_level = act_lvl;
				if (b == 0) begin
					o.finished = 1;
					if (act_lvl == tlfq_pkg::LVL_MID) pop(1);
					act_v = 0;
				end else if (act_lvl == tlfq_pkg::LVL_TOP && slice == 0) begin
					void'(push(1, act_id)); act_v = 0;
				end else if (act_lvl == tlfq_pkg::LVL_MID && slice == 0) begin
					pop(1); void'(push(2, act_id)); act_v = 0;
				end
			end
			pending.push_back(o);
		endfunction

		// Compare a result with the oldest expectation.
		function void check_result(tlfq_pkg::rsp_t a);
			tlfq_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.accepted !== e.accepted || a.run_valid !== e.run_valid ||
			    a.run_id !== e.run_id || a.run_level !== e.run_level ||
			    a.finished !== e.finished) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, a);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_idx;
	logic [7:0] cfg_data;
	tlfq_req_if req ();
	tlfq_rsp_if rsp ();
	sched_board board;
	bit calm;

	three_level_feedback_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls, checking each accepted result.
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) board.check_result(rsp.payload);
			rsp.ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	// Valid stays high after acceptance until the next request, an idle cycle or a drain.
	task automatic send(input logic op, input logic [3:0] id, input logic [15:0] bl);
		tlfq_pkg::req_t r;
		r.opcode = op; r.job_id = id; r.burst_len = bl;
		while (!calm && $urandom_range(99) < 13) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
		board.note_request(r);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		req.valid <= 0;
		while (board.pending.size() != 0 && guard < 100000) begin
			@(posedge clk); guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] v);
		drain();
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == tlfq_pkg::REG_QUANTUM_TOP) board.q_top = v; else board.q_mid = v;
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 35)
				send(tlfq_pkg::OP_ARRIVE, 4'($urandom),
				     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12)));
			else
				send(tlfq_pkg::OP_TICK, 4'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		board = new();
		board.clear();
		calm = 0;
		arst_n = 0;
		cfg_we = 0; cfg_idx = tlfq_pkg::REG_QUANTUM_TOP; cfg_data = 0;
		req.valid = 0; req.payload = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: idle tick, zero burst, repeated id, extremes, full top queue.
		send(tlfq_pkg::OP_TICK, 4'd0, 16'd0);
		send(tlfq_pkg::OP_ARRIVE, 4'd3, 16'd0);
		send(tlfq_pkg::OP_TICK, 4'd0, 16'd0);
		send(tlfq_pkg::OP_ARRIVE, 4'd15, 16'hFFFF);
		send(tlfq_pkg::OP_ARRIVE, 4'd0, 16'd1);
		send(tlfq_pkg::OP_ARRIVE, 4'd15, 16'd7);
		for (int i = 0; i < 17; i++) send(tlfq_pkg::OP_ARRIVE, 4'(i), 16'd3);
		repeat (6) send(tlfq_pkg::OP_TICK, 4'hF, 16'hFFFF);

		// Sender holds off until every result is in.
		drain();
		write_reg(tlfq_pkg::REG_QUANTUM_TOP, 8'd1);
		write_reg(tlfq_pkg::REG_QUANTUM_MID, 8'd1);
		random_phase(300);
		write_reg(tlfq_pkg::REG_QUANTUM_TOP, 8'd0);
		write_reg(tlfq_pkg::REG_QUANTUM_MID, 8'd255);
		random_phase(300);
		write_reg(tlfq_pkg::REG_QUANTUM_TOP, 8'd255);
		write_reg(tlfq_pkg::REG_QUANTUM_MID, 8'd0);
		random_phase(300);
		write_reg(tlfq_pkg::REG_QUANTUM_TOP, 8'd3);
		write_reg(tlfq_pkg::REG_QUANTUM_MID, 8'd5);
		calm = 1;
		random_phase(400);
		calm = 0;
		random_phase(700);

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
